// ----- sv/dad_pkg.sv -----
// ----------------------------------------------------------------------------
// dad_pkg
// Shared widths, month table and year tracker control for the date adder.
// ----------------------------------------------------------------------------
`default_nettype none

package dad_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int DAYS_W  = 16;
  localparam int ACC_W   = DAYS_W + 1;
  localparam int DIFF_W  = ACC_W + 1;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] FEB_LEAP_LEN = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef struct packed {
    logic load;
    logic split;
    logic fold;
    logic adv;
  } yr_ctl_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    len = MONTH_LEN[m];
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- sv/dad_if.sv -----
// ----------------------------------------------------------------------------
// dad_if
// Valid/ready channels carrying a start date beat and a result date beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dad_in_if;
  logic                            valid;
  logic                            ready;
  logic [dad_pkg::YEAR_W-1:0]      start_year;
  logic [dad_pkg::MONTH_W-1:0]     start_month;
  logic [dad_pkg::DAY_W-1:0]       start_day;
  logic [dad_pkg::DAYS_W-1:0]      days_to_add;

  modport source (output valid, start_year, start_month, start_day, days_to_add,
                  input ready);
  modport sink   (input valid, start_year, start_month, start_day, days_to_add,
                  output ready);
endinterface

interface dad_out_if;
  logic                            valid;
  logic                            ready;
  logic [dad_pkg::YEAR_W-1:0]      end_year;
  logic [dad_pkg::MONTH_W-1:0]     end_month;
  logic [dad_pkg::DAY_W-1:0]       end_day;

  modport source (output valid, end_year, end_month, end_day, input ready);
  modport sink   (input valid, end_year, end_month, end_day, output ready);
endinterface

`default_nettype wire

// ----- sv/dad_year_trk.sv -----
// ----------------------------------------------------------------------------
// dad_year_trk
// Year register with running year-of-century and century-mod-4 counters
// that give the leap flag without a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_year_trk (
  input  wire logic                          clk,
  input  wire dad_pkg::yr_ctl_t              ctl,
  input  wire logic [dad_pkg::YEAR_W-1:0]    load_year,
  output logic      [dad_pkg::YEAR_W-1:0]    year,
  output logic      [dad_pkg::YEAR_W-1:0]    year_next,
  output logic                               leap
);

  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          RECIP_SH  = 19;
  localparam logic [6:0]  CENT_LAST = 7'd99;
  localparam logic [13:0] CENT      = 14'd100;
  localparam logic [13:0] YEAR_LAST = '1;

  logic [26:0] prod;
  logic [7:0]  quot;
  logic [13:0] quot_x100;
  logic [6:0]  ymod;
  logic [1:0]  cmod;

  assign prod      = 27'(year) * 27'(RECIP_100);
  assign quot_x100 = 14'(quot) * CENT;
  assign year_next = year + 14'd1;
  assign leap      = ((ymod[1:0] == 2'd0) && (ymod != 7'd0)) ||
                     ((ymod == 7'd0) && (cmod == 2'd0));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      year <= load_year;
    end else if (ctl.adv) begin
      year <= year_next;
    end
    if (ctl.split) begin
      quot <= prod[RECIP_SH+7:RECIP_SH];
    end
    if (ctl.fold) begin
      ymod <= 7'(year - quot_x100);
      cmod <= quot[1:0];
    end else if (ctl.adv) begin
      if (year == YEAR_LAST) begin
        ymod <= 7'd0;
        cmod <= 2'd0;
      end else if (ymod == CENT_LAST) begin
        ymod <= 7'd0;
        cmod <= cmod + 2'd1;
      end else begin
        ymod <= ymod + 7'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- sv/dad_step.sv -----
// ----------------------------------------------------------------------------
// dad_step
// Shared subtract/compare unit: remaining days minus one month length.
// ----------------------------------------------------------------------------
`default_nettype none

module dad_step (
  input  wire logic        [dad_pkg::ACC_W-1:0]  acc,
  input  wire logic        [dad_pkg::DAY_W-1:0]  len,
  output logic signed      [dad_pkg::DIFF_W-1:0] diff,
  output logic                                   fits
);

  localparam int DIFF_W = dad_pkg::DIFF_W;

  assign diff = $signed({1'b0, acc}) - $signed(DIFF_W'(len));
  assign fits = diff[dad_pkg::DIFF_W-1] || (diff == '0);

endmodule

`default_nettype wire

// ----- sv/date_add_days_core.sv -----
// ----------------------------------------------------------------------------
// date_add_days_core
// Gregorian date plus day count, walked one month per cycle.
// Sequence: an accepted beat goes through the split and fold states to a first
//   compare in the start month, then through one walk step per month boundary crossed.
// Throughput: one beat at a time; the next beat is taken the cycle after the
//   result is issued, and the month walk through the shared unit sets the rate.
// Reset: synchronous active-high rst empties the sequencer and output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module date_add_days_core (
  input  wire logic clk,
  input  wire logic rst,
  dad_in_if.sink    req,
  dad_out_if.source rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPLIT = 3'd1;
  localparam logic [2:0] S_FOLD  = 3'd2;
  localparam logic [2:0] S_FIRST = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;

  logic [2:0]                           state;
  logic [2:0]                           state_next;
  logic [dad_pkg::MONTH_W-1:0]          month;
  logic [dad_pkg::ACC_W-1:0]            acc;
  logic                                 out_valid;
  logic [dad_pkg::YEAR_W-1:0]           out_year;
  logic [dad_pkg::MONTH_W-1:0]          out_month;
  logic [dad_pkg::DAY_W-1:0]            out_day;

  dad_pkg::yr_ctl_t                     yctl;
  logic [dad_pkg::YEAR_W-1:0]           year;
  logic [dad_pkg::YEAR_W-1:0]           year_next;
  logic                                 leap;

  logic                                 accept;
  logic                                 wrap;
  logic [dad_pkg::MONTH_W-1:0]          month_nxt;
  logic [dad_pkg::MONTH_W-1:0]          month_sel;
  logic [dad_pkg::DAY_W-1:0]            len;
  logic signed [dad_pkg::DIFF_W-1:0]    diff;
  logic                                 fits;
  logic                                 room;
  logic                                 emit;
  logic                                 step;

  assign req.ready     = (state == S_IDLE) && !rst;
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.end_year  = out_year;
  assign rsp.end_month = out_month;
  assign rsp.end_day   = out_day;

  assign wrap      = (month >= dad_pkg::MONTH_DEC);
  assign month_nxt = wrap ? dad_pkg::MONTH_JAN : month + 4'd1;
  assign month_sel = (state == S_WALK) ? month_nxt : month;
  assign len       = dad_pkg::month_len(month_sel, leap);
  assign room      = !out_valid || rsp.ready;
  assign emit      = ((state == S_FIRST) || (state == S_WALK)) && fits && room;
  assign step      = ((state == S_FIRST) || (state == S_WALK)) && !fits;

  assign yctl.load  = accept;
  assign yctl.split = (state == S_SPLIT);
  assign yctl.fold  = (state == S_FOLD);
  assign yctl.adv   = (state == S_WALK) && !fits && wrap;

  dad_year_trk u_year (
    .clk       (clk),
    .ctl       (yctl),
    .load_year (req.start_year),
    .year      (year),
    .year_next (year_next),
    .leap      (leap)
  );

  dad_step u_step (
    .acc  (acc),
    .len  (len),
    .diff (diff),
    .fits (fits)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SPLIT;
      S_SPLIT: state_next = S_FOLD;
      S_FOLD:  state_next = S_FIRST;
      S_FIRST: begin
        if (emit) begin
          state_next = S_IDLE;
        end else if (step) begin
          state_next = S_WALK;
        end
      end
      S_WALK:  if (emit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      month <= req.start_month;
      acc   <= dad_pkg::ACC_W'(req.days_to_add) + dad_pkg::ACC_W'(req.start_day);
    end else if (step) begin
      acc <= diff[dad_pkg::ACC_W-1:0];
      if (state == S_WALK) begin
        month <= month_nxt;
      end
    end
    if (emit) begin
      out_day <= acc[dad_pkg::DAY_W-1:0];
      if (state == S_WALK) begin
        out_year  <= wrap ? year_next : year;
        out_month <= month_nxt;
      end else begin
        out_year  <= year;
        out_month <= month;
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks date_add_days_core: a short table of dates (calendar edges, leap
// years, year wrap, odd months and days) followed by random dates and day
// counts. Every result beat is compared field by field against the expected
// date from the table or a behavioral date adder, under sender bursts and gaps,
// receiver stalls and a long receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD  = 10;
  localparam int LIMIT_CYCLES = 3_000_000;
  localparam int RANDOM_DATES = 247;
  localparam int HOLD_OFF     = 500;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_DIRECTED = 23;
  localparam int MAX_PRINTED  = 100;

  typedef struct packed {
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
    logic [dad_pkg::DAYS_W-1:0]  days;
  } date_req_t;

  typedef struct packed {
    logic [dad_pkg::YEAR_W-1:0]  year;
    logic [dad_pkg::MONTH_W-1:0] month;
    logic [dad_pkg::DAY_W-1:0]   day;
  } date_t;

  typedef struct packed {
    logic                        typed;
    logic [dad_pkg::YEAR_W-1:0]  y;
    logic [dad_pkg::MONTH_W-1:0] m;
    logic [dad_pkg::DAY_W-1:0]   d;
    logic [dad_pkg::DAYS_W-1:0]  n;
    logic [dad_pkg::YEAR_W-1:0]  ey;
    logic [dad_pkg::MONTH_W-1:0] em;
    logic [dad_pkg::DAY_W-1:0]   ed;
  } date_row_t;

  typedef enum int {FREE_RUN, COIN_FLIP, EVERY_FOURTH, MOSTLY_READY} stall_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dad_in_if  req ();
  dad_out_if rsp ();

  date_add_days_core uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  date_t due_dates [$];
  date_t offered_due;
  int    mismatches   = 0;
  int    results_seen = 0;
  int    cycles       = 0;
  int    hold_left    = 0;

  date_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b1,  2024,  1,  1,     0,  2024,  1,  1},
    '{1'b1,  2024,  1, 31,     0,  2024,  1, 31},
    '{1'b1,  2023,  1, 31,     1,  2023,  2,  1},
    '{1'b1,  2024,  2, 28,     1,  2024,  2, 29},
    '{1'b1,  2023,  2, 28,     1,  2023,  3,  1},
    '{1'b1,  1900,  2, 28,     1,  1900,  3,  1},
    '{1'b1,  2000,  2, 28,     1,  2000,  2, 29},
    '{1'b1,  2023, 12, 31,     1,  2024,  1,  1},
    '{1'b1,  9999, 12, 31,     1, 10000,  1,  1},
    '{1'b1, 16383, 12, 31,     1,     0,  1,  1},
    '{1'b1,     0,  2, 28,     1,     0,  2, 29},
    '{1'b1,  2023,  0, 31,     1,  2023,  1,  1},
    '{1'b1,  2023, 13,  1,    31,  2024,  1,  1},
    '{1'b1,  2023, 15, 31,     1,  2024,  1,  1},
    '{1'b1,  2023,  4, 31,     0,  2023,  5,  1},
    '{1'b1,  2023,  3,  0,     0,  2023,  3,  0},
    '{1'b1,  2023,  3,  0,    31,  2023,  3, 31},
    '{1'b1,  2023,  1,  1,   365,  2024,  1,  1},
    '{1'b0,     1,  1,  1, 65535,     0,  0,  0},
    '{1'b0, 16383, 12, 31, 65535,     0,  0,  0},
    '{1'b0,  9999, 15, 31, 65535,     0,  0,  0},
    '{1'b0,  5461, 10, 21, 43690,     0,  0,  0},
    '{1'b0, 10922,  5, 10, 21845,     0,  0,  0}
  };

  function automatic int month_days(input logic [dad_pkg::YEAR_W-1:0] y,
                                    input logic [dad_pkg::MONTH_W-1:0] m);
    int  yi;
    bit  leap;
    yi   = int'(y);
    leap = ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
    case (m)
      dad_pkg::MONTH_FEB: return leap ? 29 : 28;
      4'd4, 4'd6, 4'd9,
      4'd11:              return 30;
      default:            return 31;
    endcase
  endfunction

  function automatic date_t add_days(input date_req_t q);
    date_t r;
    int    left;
    int    len;
    bit    done;
    r.year  = q.year;
    r.month = q.month;
    left    = int'(q.days) - (month_days(q.year, q.month) - int'(q.day));
    if (left <= 0) begin
      r.day = q.day + q.days[dad_pkg::DAY_W-1:0];
    end else begin
      done = 1'b0;
      while (!done) begin
        if (r.month >= dad_pkg::MONTH_DEC) begin
          r.month = dad_pkg::MONTH_JAN;
          r.year  = r.year + 1'b1;
        end else begin
          r.month = r.month + 1'b1;
        end
        len = month_days(r.year, r.month);
        if (left <= len) begin
          done = 1'b1;
        end else begin
          left -= len;
        end
      end
      r.day = left[dad_pkg::DAY_W-1:0];
    end
    return r;
  endfunction

  function automatic date_req_t random_date();
    date_req_t q;
    int        pick;
    q.year  = dad_pkg::YEAR_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 16383)
                                                             : $urandom_range(1, 9999));
    q.month = dad_pkg::MONTH_W'(($urandom_range(0, 15) == 0) ? $urandom_range(0, 15)
                                                              : $urandom_range(1, 12));
    q.day   = dad_pkg::DAY_W'(($urandom_range(0, 15) == 0)
                              ? $urandom_range(0, 31)
                              : $urandom_range(1, month_days(q.year, q.month)));
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      q.days = dad_pkg::DAYS_W'($urandom_range(0, 31));
    end else if (pick < 80) begin
      q.days = dad_pkg::DAYS_W'($urandom_range(0, 1000));
    end else if (pick < 93) begin
      q.days = dad_pkg::DAYS_W'($urandom_range(0, 5000));
    end else begin
      q.days = dad_pkg::DAYS_W'($urandom_range(0, 65535));
    end
    return q;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic offer(input date_req_t q, input date_t due);
    @(negedge clk);
    req.valid       <= 1'b1;
    req.start_year  <= q.year;
    req.start_month <= q.month;
    req.start_day   <= q.day;
    req.days_to_add <= q.days;
    offered_due      = due;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic rest(input int n);
    repeat (n) begin
      @(negedge clk);
      req.valid       <= 1'b0;
      req.start_year  <= dad_pkg::YEAR_W'($urandom);
      req.start_month <= dad_pkg::MONTH_W'($urandom);
      req.start_day   <= dad_pkg::DAY_W'($urandom);
      req.days_to_add <= dad_pkg::DAYS_W'($urandom);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, due_dates.size());
      $display("[date_add_days_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    date_t want;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (due_dates.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %0d/%0d/%0d",
                                    rsp.end_year, rsp.end_month, rsp.end_day));
        end else begin
          want = due_dates.pop_front();
          if (rsp.end_year !== want.year)
            report_mismatch($sformatf("beat %0d end_year got %0d expected %0d",
                                      results_seen, rsp.end_year, want.year));
          if (rsp.end_month !== want.month)
            report_mismatch($sformatf("beat %0d end_month got %0d expected %0d",
                                      results_seen, rsp.end_month, want.month));
          if (rsp.end_day !== want.day)
            report_mismatch($sformatf("beat %0d end_day got %0d expected %0d",
                                      results_seen, rsp.end_day, want.day));
        end
        results_seen++;
      end
      if (req.valid && req.ready) begin
        due_dates.push_back(offered_due);
      end
    end
  end

  initial begin
    stall_e stall_mode;
    int     phase_left;
    int     tick;
    stall_mode = FREE_RUN;
    phase_left = 0;
    tick       = 0;
    rsp.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_mode = stall_e'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 120);
        end
        phase_left--;
        tick++;
        case (stall_mode)
          FREE_RUN:     rsp.ready <= 1'b1;
          COIN_FLIP:    rsp.ready <= 1'($urandom_range(0, 1));
          EVERY_FOURTH: rsp.ready <= (tick % 4 == 0);
          default:      rsp.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    date_req_t q;
    date_t     due;
    int        burst_left;
    req.valid       = 1'b0;
    req.start_year  = '0;
    req.start_month = '0;
    req.start_day   = '0;
    req.days_to_add = '0;
    offered_due     = '0;
    burst_left      = $urandom_range(1, 16);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED + RANDOM_DATES; i++) begin
      if (i < NUM_DIRECTED) begin
        q   = '{directed_rows[i].y, directed_rows[i].m, directed_rows[i].d,
                directed_rows[i].n};
        due = directed_rows[i].typed
              ? date_t'({directed_rows[i].ey, directed_rows[i].em, directed_rows[i].ed})
              : add_days(q);
      end else begin
        if (i == NUM_DIRECTED) begin
          hold_left = HOLD_OFF;
        end
        q   = random_date();
        due = add_days(q);
      end
      offer(q, due);
      burst_left--;
      if (burst_left == 0) begin
        rest($urandom_range(1, 12));
        burst_left = $urandom_range(1, 16);
      end
    end
    rest(1);

    while (due_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[date_add_days_core] OK");
    end else begin
      $display("[date_add_days_core] ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/dad_pkg.sv
sv/dad_if.sv
sv/dad_year_trk.sv
sv/dad_step.sv
sv/date_add_days_core.sv
tb/testbench.sv
